FILE: rtl/bsc_pkg.sv
`timescale 1ns / 1ps
package bsc_pkg;

	localparam int RawW   = 20;
	localparam int CoefW  = 16;
	localparam int RegW   = 48;
	localparam int IdxW   = 3;
	localparam int TempW  = 20;
	localparam int PressW = 32;
	localparam int DivW   = 64;
	localparam int DvsW   = 31;

	localparam logic signed [31:0] T_FINE_OFFSET = 32'sd128000;
	localparam logic signed [31:0] TEMP_MIN      = -32'sd524288;
	localparam logic signed [31:0] TEMP_MAX      = 32'sd524287;
	localparam logic [20:0]        PRESS_BASE    = 21'd1048576;
	localparam logic [11:0]        PRESS_SCALE   = 12'd3125;

	typedef enum logic [IdxW-1:0] {
		REG_TEMP    = 3'd0,
		REG_PRESS_A = 3'd1,
		REG_PRESS_B = 3'd2,
		REG_PRESS_C = 3'd3
	} cfg_reg_t;

	// Values that ride alongside the dividend through the divider.
	typedef struct packed {
		logic signed [TempW-1:0] temp;
		logic                    dz;
		logic                    neg;
	} div_side_t;

endpackage

FILE: rtl/bsc_div.sv
`timescale 1ns / 1ps
module bsc_div import bsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DivW-1:0]  dividend,
	input  logic [DvsW-1:0]  divisor,
	input  div_side_t        side_in,
	output logic             out_valid,
	output logic [DivW-1:0]  quotient,
	output div_side_t        side_out
);

	// One quotient bit per stage; entry 0 of each array is the stage input.
	logic             vld_s  [0:DivW];
	logic [DvsW-1:0]  rem_s  [0:DivW];
	logic [DivW-1:0]  num_s  [0:DivW];
	logic [DvsW-1:0]  dvs_s  [0:DivW];
	div_side_t        side_s [0:DivW];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign num_s[0]  = dividend;
	assign dvs_s[0]  = divisor;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < DivW; k++) begin : g_stage
		logic [DvsW:0]   trial;
		logic            ge;
		logic [DvsW:0]   diff;

		always_comb begin
			trial = {rem_s[k], num_s[k][DivW-1]};
			ge    = trial >= {1'b0, dvs_s[k]};
			diff  = ge ? (trial - {1'b0, dvs_s[k]}) : trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= diff[DvsW-1:0];
				num_s[k+1]  <= {num_s[k][DivW-2:0], ge};
				dvs_s[k+1]  <= dvs_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[DivW];
	assign quotient  = num_s[DivW];
	assign side_out  = side_s[DivW];

endmodule

FILE: rtl/baro_sensor_compensation.sv
`timescale 1ns / 1ps
// Barometric sensor compensation pipeline.
// Input channel: raw_temperature and raw_pressure with in_valid / in_stall.
// A beat is taken at a clock edge where in_valid is high and in_stall low.
// Output channel: temp_centideg, pressure_q24_8 and divisor_zero with
// out_valid / out_stall, one result beat for every input beat, in order.
// Calibration is loaded through cfg_we / cfg_index / cfg_data while the
// pipeline is empty; indexes above three are ignored.
// The pipeline has eleven stages of temperature and pressure arithmetic,
// a 64-stage divider that retires one quotient bit per stage, and six
// stages of pressure correction and clamping. Throughput is one beat per
// cycle while no result is held; the whole pipeline advances together.
// When a result is held by out_stall, in_stall rises and every stage keeps
// its contents, so nothing is lost or repeated. Bubbles advance as well.
// Reset clears all valid bits and the calibration words to zero.
module baro_sensor_compensation import bsc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IdxW-1:0]          cfg_index,
	input  logic [RegW-1:0]          cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [RawW-1:0]          raw_temperature,
	input  logic [RawW-1:0]          raw_pressure,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [TempW-1:0]  temp_centideg,
	output logic [PressW-1:0]        pressure_q24_8,
	output logic                     divisor_zero
);

	logic [RegW-1:0] temp_coeffs_q, press_a_q, press_b_q, press_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_a_q     <= '0;
			press_b_q     <= '0;
			press_c_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TEMP:    temp_coeffs_q <= cfg_data;
				REG_PRESS_A: press_a_q     <= cfg_data;
				REG_PRESS_B: press_b_q     <= cfg_data;
				REG_PRESS_C: press_c_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [CoefW-1:0]        t1, p1;
	logic signed [CoefW-1:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = temp_coeffs_q[15:0];
	assign t2 = temp_coeffs_q[31:16];
	assign t3 = temp_coeffs_q[47:32];
	assign p1 = press_a_q[15:0];
	assign p2 = press_a_q[31:16];
	assign p3 = press_a_q[47:32];
	assign p4 = press_b_q[15:0];
	assign p5 = press_b_q[31:16];
	assign p6 = press_b_q[47:32];
	assign p7 = press_c_q[15:0];
	assign p8 = press_c_q[31:16];
	assign p9 = press_c_q[47:32];

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11, vld_s76, vld_s77, vld_s78, vld_s79, vld_s80, vld_s81;
	logic div_vld;

	assign en       = !(vld_s81 && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9 <= 1'b0; vld_s10 <= 1'b0; vld_s11 <= 1'b0;
			vld_s76 <= 1'b0; vld_s77 <= 1'b0; vld_s78 <= 1'b0;
			vld_s79 <= 1'b0; vld_s80 <= 1'b0; vld_s81 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid; vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6; vld_s8 <= vld_s7;
			vld_s9 <= vld_s8; vld_s10 <= vld_s9; vld_s11 <= vld_s10;
			vld_s76 <= div_vld; vld_s77 <= vld_s76; vld_s78 <= vld_s77;
			vld_s79 <= vld_s78; vld_s80 <= vld_s79; vld_s81 <= vld_s80;
		end
	end

	// Temperature path. Value ranges keep these narrow: t_fine stays within
	// 22 signed bits, so the 32-bit wrap only matters for the three products.
	logic signed [17:0] a_s1;
	logic signed [16:0] b_s1;
	logic [RawW-1:0]    adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7, adcp_s8;
	logic signed [33:0] at_s2, bb_s2;
	logic signed [31:0] tv1_s3;
	logic signed [47:0] bt3_s3;
	logic signed [31:0] tfine_s4;
	logic signed [TempW-1:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10, temp_s11;
	logic signed [22:0] v1_s5;
	logic signed [45:0] vv_s6;
	logic signed [38:0] v1p5_s6, v1p2_s6, v1p5_s7, v1p2_s7;
	logic signed [61:0] v2a_s7, v1a_s7;
	logic signed [63:0] v2_s8, y_s8;
	logic signed [63:0] yp_s9, nb_s9;
	logic signed [63:0] num_s10;
	logic signed [DvsW-1:0] d_s10;
	logic               dz_s10, dz_s11, neg_s11;
	logic [DivW-1:0]    an_s11;
	logic [DvsW-1:0]    ad_s11;

	logic signed [31:0] at_w, bb_w, bbs, bt3_w, tv2, t5, tt, v1_full;
	logic signed [TempW-1:0] temp_sat;
	logic signed [63:0] x_w, y_w, v2_w;
	logic signed [73:0] yp_full;
	logic [20:0]        praw;

	always_comb begin
		at_w    = at_s2[31:0];
		bb_w    = bb_s2[31:0];
		bbs     = bb_w >>> 12;
		bt3_w   = bt3_s3[31:0];
		tv2     = bt3_w >>> 14;
		t5      = tfine_s4 * 32'sd5 + 32'sd128;
		tt      = t5 >>> 8;
		if (tt < TEMP_MIN)
			temp_sat = TEMP_MIN[TempW-1:0];
		else if (tt > TEMP_MAX)
			temp_sat = TEMP_MAX[TempW-1:0];
		else
			temp_sat = tt[TempW-1:0];
		v1_full = tfine_s4 - T_FINE_OFFSET;
		v2_w    = 64'(v2a_s7) + (64'(v1p5_s7) <<< 17) + (64'(p4) <<< 35);
		x_w     = (64'(v1a_s7) >>> 8) + (64'(v1p2_s7) <<< 12);
		y_w     = x_w + (64'sd1 <<< 47);
		yp_full = $signed(y_s8[56:0]) * $signed({1'b0, p1});
		praw    = PRESS_BASE - {1'b0, adcp_s8};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
			b_s1    <= $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
			adcp_s1 <= raw_pressure;

			at_s2   <= a_s1 * t2;
			bb_s2   <= b_s1 * b_s1;
			adcp_s2 <= adcp_s1;

			tv1_s3  <= at_w >>> 11;
			bt3_s3  <= bbs * t3;
			adcp_s3 <= adcp_s2;

			tfine_s4 <= tv1_s3 + tv2;
			adcp_s4  <= adcp_s3;

			temp_s5 <= temp_sat;
			v1_s5   <= v1_full[22:0];
			adcp_s5 <= adcp_s4;

			vv_s6   <= v1_s5 * v1_s5;
			v1p5_s6 <= v1_s5 * p5;
			v1p2_s6 <= v1_s5 * p2;
			temp_s6 <= temp_s5;
			adcp_s6 <= adcp_s5;

			v2a_s7  <= vv_s6 * p6;
			v1a_s7  <= vv_s6 * p3;
			v1p5_s7 <= v1p5_s6;
			v1p2_s7 <= v1p2_s6;
			temp_s7 <= temp_s6;
			adcp_s7 <= adcp_s6;

			v2_s8   <= v2_w;
			y_s8    <= y_w;
			temp_s8 <= temp_s7;
			adcp_s8 <= adcp_s7;

			yp_s9   <= yp_full[63:0];
			nb_s9   <= $signed({praw, 31'b0} - v2_s8);
			temp_s9 <= temp_s8;

			d_s10    <= yp_s9[63:33];
			dz_s10   <= (yp_s9[63:33] == '0);
			num_s10  <= nb_s9 * $signed({1'b0, PRESS_SCALE});
			temp_s10 <= temp_s9;

			an_s11   <= num_s10[63] ? (64'd0 - num_s10) : num_s10;
			ad_s11   <= d_s10[DvsW-1] ? (31'd0 - d_s10) : d_s10;
			neg_s11  <= num_s10[63] ^ d_s10[DvsW-1];
			dz_s11   <= dz_s10;
			temp_s11 <= temp_s10;
		end
	end

	div_side_t       side_in, side_out;
	logic [DivW-1:0] quot;

	assign side_in = '{temp: temp_s11, dz: dz_s11, neg: neg_s11};

	bsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s11),
		.dividend (an_s11),
		.divisor  (ad_s11),
		.side_in  (side_in),
		.out_valid(div_vld),
		.quotient (quot),
		.side_out (side_out)
	);

	// Pressure correction. 64-bit wrapping products are built from 32-bit
	// halves: only the low word of each cross product survives the wrap.
	logic signed [63:0] q_s76, q_s77, q_s78, q_s79;
	div_side_t          side_s76, side_s77, side_s78, side_s79, side_s80;
	logic [63:0]        pl_s77, sq_s78;
	logic [31:0]        cr_s77, p8hi_s77, m_hi_s79;
	logic signed [48:0] p8lo_s77, m_lo_s79;
	logic signed [63:0] w2_s78, w2_s79, s_s80;
	logic signed [TempW-1:0] temp_s81;
	logic [PressW-1:0]  press_s81;
	logic               dz_s81;

	logic signed [63:0] ph, w2_sum, m_w, w1, r_w;
	logic [31:0]        p8x, p9x;
	logic [PressW-1:0]  press_w;

	always_comb begin
		ph     = q_s76 >>> 13;
		p8x    = 32'(p8);
		p9x    = 32'(p9);
		w2_sum = 64'(p8lo_s77) + $signed({p8hi_s77, 32'b0});
		m_w    = 64'(m_lo_s79) + $signed({m_hi_s79, 32'b0});
		w1     = m_w >>> 25;
		r_w    = (s_s80 >>> 8) + (64'(p7) <<< 4);
		if (side_s80.dz || r_w[63])
			press_w = '0;
		else if (|r_w[63:32])
			press_w = '1;
		else
			press_w = r_w[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s76    <= side_out.neg ? $signed(64'd0 - quot) : $signed(quot);
			side_s76 <= side_out;

			pl_s77   <= ph[31:0] * ph[31:0];
			cr_s77   <= ph[31:0] * ph[63:32];
			p8lo_s77 <= $signed({1'b0, q_s76[31:0]}) * p8;
			p8hi_s77 <= q_s76[63:32] * p8x;
			q_s77    <= q_s76;
			side_s77 <= side_s76;

			sq_s78   <= pl_s77 + {cr_s77[30:0], 33'b0};
			w2_s78   <= w2_sum >>> 19;
			q_s78    <= q_s77;
			side_s78 <= side_s77;

			m_lo_s79 <= $signed({1'b0, sq_s78[31:0]}) * p9;
			m_hi_s79 <= sq_s78[63:32] * p9x;
			w2_s79   <= w2_s78;
			q_s79    <= q_s78;
			side_s79 <= side_s78;

			s_s80    <= q_s79 + w1 + w2_s79;
			side_s80 <= side_s79;

			press_s81 <= press_w;
			temp_s81  <= side_s80.temp;
			dz_s81    <= side_s80.dz;
		end
	end

	assign out_valid      = vld_s81;
	assign temp_centideg  = temp_s81;
	assign pressure_q24_8 = press_s81;
	assign divisor_zero   = dz_s81;

	a_dz_forces_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divisor_zero |-> pressure_q24_8 == '0)
		else $error("zero divisor result carries nonzero pressure");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	a_entry_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s1)
		else $error("accepted beat did not enter the first stage");

	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s11) && $stable(div_vld))
		else $error("pipeline moved while output was held");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import bsc_pkg::*;

	localparam int CycleLimit = 600000;
	localparam int DrainWait = 100;
	localparam int LongHold = 400;
	localparam logic [IdxW-1:0] IDX_SPARE_LO = 3'd4;
	localparam logic [IdxW-1:0] IDX_SPARE_HI = 3'd7;

	typedef struct {
		logic signed [TempW-1:0] temp;
		logic [PressW-1:0]       press;
		logic                    dz;
	} comp_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IdxW-1:0] cfg_index;
	logic [RegW-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [RawW-1:0] raw_temperature;
	logic [RawW-1:0] raw_pressure;
	logic out_valid;
	logic out_stall;
	logic signed [TempW-1:0] temp_centideg;
	logic [PressW-1:0] pressure_q24_8;
	logic divisor_zero;

	logic [RegW-1:0] calib[4];
	comp_result_t pending_results[$];
	int mismatches = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int dz_seen = 0;
	int burst_left = 0;
	int cycle_count = 0;
	bit hold_req = 0;

	baro_sensor_compensation uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
		.out_valid(out_valid), .out_stall(out_stall), .temp_centideg(temp_centideg),
		.pressure_q24_8(pressure_q24_8), .divisor_zero(divisor_zero)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Integer compensation: 32-bit wrap for temperature, 64-bit for pressure.
	function automatic comp_result_t compensate(logic [RawW-1:0] rt, logic [RawW-1:0] rp);
		comp_result_t r;
		logic signed [31:0] adc, t1, t2, t3, a, b, m, tv1, tv2, t_fine, tc;
		logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] v1, v2, w, num, pv, ph, w1, w2;
		logic [63:0] an, ad, q;
		adc = {12'b0, rt};
		t1 = {16'b0, calib[REG_TEMP][15:0]};
		t2 = $signed(calib[REG_TEMP][31:16]);
		t3 = $signed(calib[REG_TEMP][47:32]);
		p1 = {48'b0, calib[REG_PRESS_A][15:0]};
		p2 = $signed(calib[REG_PRESS_A][31:16]);
		p3 = $signed(calib[REG_PRESS_A][47:32]);
		p4 = $signed(calib[REG_PRESS_B][15:0]);
		p5 = $signed(calib[REG_PRESS_B][31:16]);
		p6 = $signed(calib[REG_PRESS_B][47:32]);
		p7 = $signed(calib[REG_PRESS_C][15:0]);
		p8 = $signed(calib[REG_PRESS_C][31:16]);
		p9 = $signed(calib[REG_PRESS_C][47:32]);

		a = (adc >>> 3) - (t1 <<< 1);
		m = a * t2;
		tv1 = m >>> 11;
		b = (adc >>> 4) - t1;
		m = b * b;
		m = m >>> 12;
		m = m * t3;
		tv2 = m >>> 14;
		t_fine = tv1 + tv2;
		m = t_fine * 32'sd5 + 32'sd128;
		tc = m >>> 8;
		if (tc < TEMP_MIN)
			tc = TEMP_MIN;
		else if (tc > TEMP_MAX)
			tc = TEMP_MAX;
		r.temp = tc[TempW-1:0];

		v1 = t_fine;
		v1 = v1 - 64'sd128000;
		v2 = v1 * v1 * p6;
		w = v1 * p5;
		v2 = v2 + (w <<< 17) + (p4 <<< 35);
		w = v1 * v1 * p3;
		w = w >>> 8;
		v1 = v1 * p2;
		v1 = w + (v1 <<< 12);
		w = ((64'sd1 <<< 47) + v1) * p1;
		v1 = w >>> 33;

		r.press = '0;
		r.dz = 1'b0;
		if (v1 == 0) begin
			r.dz = 1'b1;
		end else begin
			pv = 64'sd1048576 - $signed({44'b0, rp});
			num = ((pv <<< 31) - v2) * 64'sd3125;
			an = num[63] ? -num : num;
			ad = v1[63] ? -v1 : v1;
			q = an / ad;
			pv = (num[63] ^ v1[63]) ? -q : q;
			ph = pv >>> 13;
			w1 = p9 * ph * ph;
			w1 = w1 >>> 25;
			w2 = p8 * pv;
			w2 = w2 >>> 19;
			w = pv + w1 + w2;
			pv = (w >>> 8) + (p7 <<< 4);
			if (pv < 0)
				r.press = '0;
			else if (pv > 64'sd4294967295)
				r.press = '1;
			else
				r.press = pv[31:0];
		end
		return r;
	endfunction

	task automatic cfg_write(logic [IdxW-1:0] idx, logic [RegW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < 4)
			calib[idx[1:0]] = data;
	endtask

	task automatic load_calib(logic [RegW-1:0] c0, c1, c2, c3);
		cfg_write(REG_TEMP, c0);
		cfg_write(REG_PRESS_A, c1);
		cfg_write(REG_PRESS_B, c2);
		cfg_write(REG_PRESS_C, c3);
	endtask

	// Sender works in bursts; valid stays high across back-to-back beats.
	task automatic send_sample(logic [RawW-1:0] rt, logic [RawW-1:0] rp);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		raw_temperature <= rt;
		raw_pressure <= rp;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(compensate(rt, rp));
		beats_sent++;
		burst_left--;
	endtask

	// Waits for the pipeline to empty so calibration can change safely.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	function automatic logic [RegW-1:0] typical_temp_coeffs;
		return {16'hFC18, 16'd26435, 16'd27504};
	endfunction

	function automatic logic [RegW-1:0] jitter(logic [RegW-1:0] w);
		logic [RegW-1:0] r;
		for (int i = 0; i < 3; i++)
			r[16*i +: 16] = w[16*i +: 16] + 16'($urandom_range(0, 64)) - 16'd32;
		return r;
	endfunction

	localparam logic [RegW-1:0] TYP_PA = {16'd3024, 16'hD643, 16'd36477};
	localparam logic [RegW-1:0] TYP_PB = {16'hFFF9, 16'd140, 16'd2855};
	localparam logic [RegW-1:0] TYP_PC = {16'd6000, 16'hC6F8, 16'd15500};

	task automatic test_reset_calibration;
		// All coefficients are zero after reset, so the divisor is zero.
		send_sample(20'd0, 20'd0);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'd519888, 20'd415148);
		drain();
	endtask

	task automatic test_directed;
		load_calib(typical_temp_coeffs(), TYP_PA, TYP_PB, TYP_PC);
		send_sample(20'd519888, 20'd415148);
		send_sample(20'd0, 20'd0);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'd0, 20'hFFFFF);
		send_sample(20'hFFFFF, 20'd0);
		send_sample(20'h80000, 20'h7FFFF);
		drain();
		// Writes to unused indexes must leave the calibration alone.
		cfg_write(IDX_SPARE_LO, '1);
		cfg_write(IDX_SPARE_HI, '1);
		send_sample(20'd519888, 20'd415148);
		send_sample(20'h55555, 20'hAAAAA);
		drain();
		load_calib('1, '1, '1, '1);
		send_sample(20'd0, 20'd0);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'h12345, 20'h54321);
		drain();
		load_calib({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
		send_sample(20'd0, 20'hFFFFF);
		send_sample(20'hFFFFF, 20'd0);
		send_sample(20'h7FFFF, 20'h80000);
		drain();
		load_calib({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
		send_sample(20'd0, 20'd0);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'h40000, 20'h40000);
		drain();
		// P1 of zero forces the zero-divisor path with a live temperature.
		load_calib(typical_temp_coeffs(), {TYP_PA[47:16], 16'd0}, TYP_PB, TYP_PC);
		send_sample(20'd519888, 20'd415148);
		send_sample(20'hFFFFF, 20'd0);
		drain();
	endtask

	task automatic test_random_typical;
		load_calib(jitter(typical_temp_coeffs()), jitter(TYP_PA), jitter(TYP_PB),
			jitter(TYP_PC));
		hold_req = 1;
		for (int i = 0; i < 600; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_sample(20'($urandom), 20'($urandom));
			else
				send_sample(20'($urandom_range(380000, 620000)),
					20'($urandom_range(200000, 650000)));
		end
		drain();
	endtask

	task automatic test_random_calibration;
		for (int ph = 0; ph < 10; ph++) begin
			load_calib(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
				48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
			if (ph == 9)
				cfg_write(REG_PRESS_A, {calib[REG_PRESS_A][47:16], 16'd0});
			for (int i = 0; i < 95; i++)
				send_sample(20'($urandom), 20'($urandom));
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		raw_temperature = '0;
		raw_pressure = '0;
		for (int i = 0; i < 4; i++)
			calib[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_calibration();
		test_directed();
		test_random_typical();
		test_random_calibration();
		$display("Sent %0d beats, checked %0d results, %0d with a zero divisor.",
			beats_sent, results_seen, dz_seen);
		$display("Covered reset, extreme and random calibrations plus a long output hold.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver: quiet windows, random stalls, and one long hold on request.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 0;
				hold_left = LongHold;
				out_stall <= 1'b1;
			end else if (cycle_count[8:7] == 2'b00) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
			end
		end
	end

	always @(posedge clk) begin
		comp_result_t e;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation waiting");
				mismatches++;
			end else begin
				e = pending_results.pop_front();
				if (e.dz)
					dz_seen++;
				if (temp_centideg !== e.temp) begin
					$error("temp_centideg: expected %0d, actual %0d", e.temp, temp_centideg);
					mismatches++;
				end
				if (pressure_q24_8 !== e.press) begin
					$error("pressure_q24_8: expected %0d, actual %0d", e.press,
						pressure_q24_8);
					mismatches++;
				end
				if (divisor_zero !== e.dz) begin
					$error("divisor_zero: expected %0d, actual %0d", e.dz, divisor_zero);
					mismatches++;
				end
			end
		end
	end

endmodule
